/* rtl/sgr_pkg.sv */
`timescale 1ns / 1ps
// shared widths, codes and gain curve segments for the speaker gain ramp
package sgr_pkg;

    localparam int MUL_W  = 16;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DEN_W  = 17;

    localparam int GAIN_SCALE  = 32768;
    localparam int SPEECH_RAMP = 480;

    localparam logic [15:0] FADE_RESET = 16'd4800;
    localparam logic [6:0]  VOL_RESET  = 7'd70;
    localparam logic [6:0]  VOL_MAX    = 7'd100;
    localparam logic [6:0]  AI_FLOOR   = 7'd20;
    localparam logic [6:0]  AI_OFFSET  = 7'd20;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_VOLUME = 2'd1;
    localparam logic [1:0] FUNC_SOURCE = 2'd2;

    localparam logic [1:0] SRC_SYSTEM = 2'd0;
    localparam logic [1:0] SRC_SPEECH = 2'd1;
    localparam logic [1:0] SRC_MEDIA  = 2'd2;

    localparam logic REG_FADE_LEN = 1'b0;
    localparam logic REG_OUT_EN   = 1'b1;

    typedef struct packed {
        logic [6:0]  lv;
        logic [14:0] lg;
        logic [13:0] dg;
        logic [4:0]  dv;
    } t_seg;

    // piecewise-linear curve segment holding volume v
    function automatic t_seg curve_seg(input logic [6:0] v);
        t_seg s;
        case (v) inside
            [7'd0:7'd5]:   s = '{7'd0,  15'd0,     14'd146,  5'd5};
            [7'd6:7'd10]:  s = '{7'd5,  15'd146,   14'd267,  5'd5};
            [7'd11:7'd20]: s = '{7'd10, 15'd413,   14'd750,  5'd10};
            [7'd21:7'd30]: s = '{7'd20, 15'd1163,  14'd1157, 5'd10};
            [7'd31:7'd40]: s = '{7'd30, 15'd2320,  14'd1805, 5'd10};
            [7'd41:7'd50]: s = '{7'd40, 15'd4125,  14'd2413, 5'd10};
            [7'd51:7'd60]: s = '{7'd50, 15'd6538,  14'd3824, 5'd10};
            [7'd61:7'd80]: s = '{7'd60, 15'd10362, 14'd6061, 5'd20};
            default:       s = '{7'd80, 15'd16423, 14'd9791, 5'd20};
        endcase
        return s;
    endfunction

    // speech volume: lowered by the offset with a floor, zero stays zero
    function automatic logic [6:0] speech_volume(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd0;
        end else if (v < AI_FLOOR + AI_OFFSET) begin
            r = AI_FLOOR;
        end else begin
            r = v - AI_OFFSET;
        end
        return r;
    endfunction

endpackage

/* rtl/sgr_mul.sv */
`timescale 1ns / 1ps
// bit-serial shift-add multiplier, one multiplier bit per cycle
module sgr_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sgr_pkg::MUL_W-1:0]   i_a,
    input  logic [sgr_pkg::MUL_W-1:0]   i_b,
    output logic                        o_done,
    output logic [sgr_pkg::PROD_W-1:0]  o_prod
);

    localparam int CW = $clog2(sgr_pkg::MUL_W);
    localparam int MW = sgr_pkg::MUL_W;

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [sgr_pkg::PROD_W-1:0]  r_acc;
    logic [MW-1:0]               r_a;
    logic [MW:0]                 w_sum;
    logic [sgr_pkg::PROD_W-1:0]  n_acc;

    always_comb begin
        w_sum = {1'b0, r_acc[sgr_pkg::PROD_W-1:MW]} + (r_acc[0] ? {1'b0, r_a} : '0);
        n_acc = {w_sum, r_acc[MW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{MW{1'b0}}, i_b};
            r_a   <= i_a;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* rtl/sgr_div.sv */
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module sgr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sgr_pkg::PROD_W-1:0]  i_num,
    input  logic [sgr_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [sgr_pkg::PROD_W-1:0]  o_quot
);

    localparam int PW = sgr_pkg::PROD_W;
    localparam int DW = sgr_pkg::DEN_W;
    localparam int CW = $clog2(PW);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  r_q;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [DW:0]    w_sh;
    logic [DW+1:0]  w_diff;
    logic           w_fit;

    always_comb begin
        w_sh   = {r_rem, r_q[PW-1]};
        w_diff = {1'b0, w_sh} - {2'b00, r_den};
        w_fit  = !w_diff[DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(PW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[PW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DW-1:0] : w_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/speaker_gain_ramp_unit.sv */
`timescale 1ns / 1ps
// top level of the speaker gain ramp: item sequencer, gain state and output register
//
// Mono volume stage. Each item is a sample, a volume change or a source change.
// All arithmetic runs through one bit-serial multiplier followed by one
// bit-serial divider, which together make one multiply-divide pass. A sample
// with the output enabled takes one pass for the scaling, plus one more while
// a gain ramp is under way. A volume or source change takes two passes for the
// curve lookups. Ignored items (output disabled, reserved codes) start no pass.
// A finished sample waits in the output register, and the next item is taken
// once the result has moved there. Configuration writes are always ready.
module speaker_gain_ramp_unit #(
    parameter int P_GAIN_SCALE  = sgr_pkg::GAIN_SCALE,
    parameter int P_SPEECH_RAMP = sgr_pkg::SPEECH_RAMP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_sample_in,
    input  logic [6:0]         i_volume,
    input  logic [1:0]         i_source,
    input  logic               i_stream_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample_out,
    output logic [14:0]        o_gain_used,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam logic [sgr_pkg::DEN_W-1:0] L_GS     = sgr_pkg::DEN_W'(P_GAIN_SCALE);
    localparam logic [15:0]               L_SPEECH = 16'(P_SPEECH_RAMP);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    localparam logic [1:0] JOB_CURVE_U = 2'd0;
    localparam logic [1:0] JOB_CURVE_A = 2'd1;
    localparam logic [1:0] JOB_RAMP    = 2'd2;
    localparam logic [1:0] JOB_SCALE   = 2'd3;

    // control and gain state
    logic [2:0]  r_state, n_state;
    logic [1:0]  r_job, n_job;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_mfl;
    logic        r_oen;
    logic [6:0]  r_user_vol, n_user_vol;
    logic [1:0]  r_act_src, n_act_src;
    logic [14:0] r_gain_now, n_gain_now;
    logic [14:0] r_gain_tgt, n_gain_tgt;
    logic [14:0] r_gain_start, n_gain_start;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;

    // item payload and intermediate results
    logic [15:0] r_sample, n_sample;
    logic [1:0]  r_func, n_func;
    logic [1:0]  r_src, n_src;
    logic        r_start, n_start;
    logic [6:0]  r_vu, n_vu;
    logic [14:0] r_gu, n_gu;
    logic [14:0] r_ga, n_ga;
    logic [15:0] r_res, n_res;
    logic [15:0] r_o_sample, n_o_sample;
    logic [14:0] r_o_gain, n_o_gain;

    logic                         w_in_acc;
    logic [6:0]                   w_va;
    logic [6:0]                   w_cv;
    sgr_pkg::t_seg                w_seg;
    logic                         w_up;
    logic [14:0]                  w_dmag;
    logic [15:0]                  w_pos_inc;
    logic [sgr_pkg::MUL_W-1:0]    w_op_a;
    logic [sgr_pkg::MUL_W-1:0]    w_op_b;
    logic [sgr_pkg::DEN_W-1:0]    w_op_d;
    logic                         w_mul_start;
    logic                         w_mul_done;
    logic [sgr_pkg::PROD_W-1:0]   w_prod;
    logic                         w_div_done;
    logic [sgr_pkg::PROD_W-1:0]   w_quot;
    logic                         w_neg;
    logic [14:0]                  w_ramp_g;
    logic                         w_changed;

    assign o_stall     = (r_state != S_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_o_sample;
    assign o_gain_used  = r_o_gain;

    // operands of the current multiply-divide pass
    always_comb begin
        w_va      = sgr_pkg::speech_volume(r_vu);
        w_cv      = (r_job == JOB_CURVE_A) ? w_va : r_vu;
        w_seg     = sgr_pkg::curve_seg(w_cv);
        w_up      = (r_gain_tgt >= r_gain_start);
        w_dmag    = w_up ? (r_gain_tgt - r_gain_start) : (r_gain_start - r_gain_tgt);
        w_pos_inc = r_pos + 16'd1;
        case (r_job)
            JOB_CURVE_U, JOB_CURVE_A: begin
                w_op_a = sgr_pkg::MUL_W'(w_seg.dg);
                w_op_b = sgr_pkg::MUL_W'(w_cv - w_seg.lv);
                w_op_d = sgr_pkg::DEN_W'(w_seg.dv);
            end
            JOB_RAMP: begin
                w_op_a = sgr_pkg::MUL_W'(w_dmag);
                w_op_b = w_pos_inc;
                w_op_d = sgr_pkg::DEN_W'(r_len);
            end
            default: begin
                w_op_a = r_sample[15] ? (~r_sample + 16'd1) : r_sample;
                w_op_b = sgr_pkg::MUL_W'(r_gain_now);
                w_op_d = L_GS;
            end
        endcase
    end

    assign w_mul_start = (r_state == S_LAUNCH);

    sgr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    sgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_done),
        .i_num   (w_prod),
        .i_den   (w_op_d),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // sign and ramp step from the quotient, and whether the source changes
    always_comb begin
        w_neg = r_sample[15] && (w_quot != '0);
        if (w_up) begin
            w_ramp_g = r_gain_start + w_quot[14:0];
        end else begin
            w_ramp_g = r_gain_start - w_quot[14:0];
        end
        w_changed = (r_act_src != r_src);
    end

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_ovalid     = r_ovalid && i_stall;
        n_user_vol   = r_user_vol;
        n_act_src    = r_act_src;
        n_gain_now   = r_gain_now;
        n_gain_tgt   = r_gain_tgt;
        n_gain_start = r_gain_start;
        n_pos        = r_pos;
        n_len        = r_len;
        n_sample     = r_sample;
        n_func       = r_func;
        n_src        = r_src;
        n_start      = r_start;
        n_vu         = r_vu;
        n_gu         = r_gu;
        n_ga         = r_ga;
        n_res        = r_res;
        n_o_sample   = r_o_sample;
        n_o_gain     = r_o_gain;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sample = i_sample_in;
                    n_func   = i_func;
                    n_src    = i_source;
                    n_start  = i_stream_start;
                    case (i_func)
                        sgr_pkg::FUNC_SAMPLE: begin
                            if (r_oen) begin
                                n_job   = (r_pos < r_len) ? JOB_RAMP : JOB_SCALE;
                                n_state = S_LAUNCH;
                            end
                        end
                        sgr_pkg::FUNC_VOLUME: begin
                            n_vu    = (i_volume > sgr_pkg::VOL_MAX) ? sgr_pkg::VOL_MAX
                                                                   : i_volume;
                            n_job   = JOB_CURVE_U;
                            n_state = S_LAUNCH;
                        end
                        sgr_pkg::FUNC_SOURCE: begin
                            if (i_source == sgr_pkg::SRC_SYSTEM ||
                                i_source == sgr_pkg::SRC_SPEECH ||
                                i_source == sgr_pkg::SRC_MEDIA) begin
                                n_vu    = r_user_vol;
                                n_job   = JOB_CURVE_U;
                                n_state = S_LAUNCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LAUNCH: begin
                n_state = S_MUL;
                if (r_job == JOB_RAMP) begin
                    n_pos = w_pos_inc;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    case (r_job)
                        JOB_CURVE_U: begin
                            n_gu    = w_seg.lg + w_quot[14:0];
                            n_job   = JOB_CURVE_A;
                            n_state = S_LAUNCH;
                        end
                        JOB_CURVE_A: begin
                            n_ga    = w_seg.lg + w_quot[14:0];
                            n_state = S_APPLY;
                        end
                        JOB_RAMP: begin
                            n_gain_now = (r_pos == r_len) ? r_gain_tgt : w_ramp_g;
                            n_job      = JOB_SCALE;
                            n_state    = S_LAUNCH;
                        end
                        default: begin
                            if (!w_neg) begin
                                n_res = (|w_quot[sgr_pkg::PROD_W-1:15]) ? 16'h7FFF
                                                                       : w_quot[15:0];
                            end else if ((|w_quot[sgr_pkg::PROD_W-1:16]) ||
                                         (w_quot[15] && (|w_quot[14:0]))) begin
                                n_res = 16'h8000;
                            end else begin
                                n_res = ~w_quot[15:0] + 16'd1;
                            end
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
                if (r_func == sgr_pkg::FUNC_VOLUME) begin
                    n_user_vol = r_vu;
                    if (r_vu == 7'd0 || r_act_src == sgr_pkg::SRC_SYSTEM) begin
                        n_gain_now   = r_gu;
                        n_gain_tgt   = r_gu;
                        n_gain_start = r_gu;
                        n_pos        = '0;
                        n_len        = '0;
                    end else if (r_act_src == sgr_pkg::SRC_SPEECH) begin
                        n_gain_start = r_gain_now;
                        n_gain_tgt   = r_ga;
                        n_pos        = '0;
                        n_len        = L_SPEECH;
                    end else if (r_len > r_pos) begin
                        n_gain_start = r_gain_now;
                        n_gain_tgt   = r_gu;
                        n_pos        = '0;
                        n_len        = r_len - r_pos;
                    end else begin
                        n_gain_now   = r_gu;
                        n_gain_tgt   = r_gu;
                        n_gain_start = r_gu;
                        n_pos        = '0;
                        n_len        = '0;
                    end
                end else begin
                    n_act_src = r_src;
                    if (r_vu == 7'd0) begin
                        n_gain_now   = '0;
                        n_gain_tgt   = '0;
                        n_gain_start = '0;
                        n_pos        = '0;
                        n_len        = '0;
                    end else if (r_src == sgr_pkg::SRC_SPEECH) begin
                        if (w_changed || (r_pos >= r_len && r_gain_tgt != r_ga)) begin
                            n_gain_now   = r_ga;
                            n_gain_tgt   = r_ga;
                            n_gain_start = r_ga;
                            n_pos        = '0;
                            n_len        = '0;
                        end
                    end else if (r_src == sgr_pkg::SRC_MEDIA && r_start) begin
                        if (r_mfl == 16'd0) begin
                            n_gain_now   = r_gu;
                            n_gain_tgt   = r_gu;
                            n_gain_start = r_gu;
                            n_pos        = '0;
                            n_len        = '0;
                        end else begin
                            n_gain_now   = '0;
                            n_gain_start = '0;
                            n_gain_tgt   = r_gu;
                            n_pos        = '0;
                            n_len        = r_mfl;
                        end
                    end else if (r_src == sgr_pkg::SRC_MEDIA && r_pos < r_len) begin
                        if (r_gain_tgt != r_gu) begin
                            n_gain_start = r_gain_now;
                            n_gain_tgt   = r_gu;
                            n_pos        = '0;
                            n_len        = r_len - r_pos;
                        end
                    end else begin
                        n_gain_now   = r_gu;
                        n_gain_tgt   = r_gu;
                        n_gain_start = r_gu;
                        n_pos        = '0;
                        n_len        = '0;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid   = 1'b1;
                    n_o_sample = r_res;
                    n_o_gain   = r_gain_now;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_job        <= JOB_CURVE_U;
            r_ovalid     <= 1'b0;
            r_user_vol   <= sgr_pkg::VOL_RESET;
            r_act_src    <= sgr_pkg::SRC_SYSTEM;
            r_gain_now   <= '0;
            r_gain_tgt   <= '0;
            r_gain_start <= '0;
            r_pos        <= '0;
            r_len        <= '0;
        end else begin
            r_state      <= n_state;
            r_job        <= n_job;
            r_ovalid     <= n_ovalid;
            r_user_vol   <= n_user_vol;
            r_act_src    <= n_act_src;
            r_gain_now   <= n_gain_now;
            r_gain_tgt   <= n_gain_tgt;
            r_gain_start <= n_gain_start;
            r_pos        <= n_pos;
            r_len        <= n_len;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfl <= sgr_pkg::FADE_RESET;
            r_oen <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sgr_pkg::REG_FADE_LEN: r_mfl <= i_cfg_data;
                sgr_pkg::REG_OUT_EN:   r_oen <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_func     <= n_func;
        r_src      <= n_src;
        r_start    <= n_start;
        r_vu       <= n_vu;
        r_gu       <= n_gu;
        r_ga       <= n_ga;
        r_res      <= n_res;
        r_o_sample <= n_o_sample;
        r_o_gain   <= n_o_gain;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the speaker gain ramp: directed table, random phases, gain predictor
module testbench;
    import sgr_pkg::*;

    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam logic [1:0] SRC_RESERVED  = 2'd3;
    localparam int SETTLE_CYC = 300;
    localparam int HOLD_CYC   = 400;
    localparam int WATCHDOG   = 4000;
    localparam int MAX_PRINT  = 50;

    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] smp;
        logic [6:0]         vol;
        logic [1:0]         src;
        logic               start;
    } t_item;

    typedef struct {
        logic signed [15:0] smp;
        logic [14:0]        gain;
    } t_res;

    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_data;
        t_item       it;
        bit          typed;
        t_res        res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_func = FUNC_SAMPLE;
    logic signed [15:0] i_sample_in = '0;
    logic [6:0]         i_volume = '0;
    logic [1:0]         i_source = SRC_SYSTEM;
    logic               i_stream_start = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_sample_out;
    logic [14:0]        o_gain_used;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = REG_FADE_LEN;
    logic [15:0]        i_cfg_data = '0;

    speaker_gain_ramp_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_sample_in    (i_sample_in),
        .i_volume       (i_volume),
        .i_source       (i_source),
        .i_stream_start (i_stream_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_out   (o_sample_out),
        .o_gain_used    (o_gain_used),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted gain stage state
    logic [15:0] fade_len;
    logic        out_en;
    logic [6:0]  user_vol;
    logic [1:0]  cur_src;
    logic [14:0] gain_now;
    logic [14:0] gain_tgt;
    logic [14:0] gain_beg;
    logic [15:0] ramp_pos;
    logic [15:0] ramp_len;

    t_res expected_out[$];
    t_row dir_rows[$];
    int   n_errors = 0;
    int   n_items = 0;
    int   n_results = 0;
    int   n_cfg = 0;
    int   idle_cycles = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    bit   hold_req = 1'b0;

    task automatic report_fail(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINT) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [14:0] curve_gain(input logic [6:0] v);
        int x, lv, lg, hv, hg;
        x = (v > VOL_MAX) ? 100 : int'(v);
        if (x <= 5) begin
            lv = 0;  lg = 0;     hv = 5;   hg = 146;
        end else if (x <= 10) begin
            lv = 5;  lg = 146;   hv = 10;  hg = 413;
        end else if (x <= 20) begin
            lv = 10; lg = 413;   hv = 20;  hg = 1163;
        end else if (x <= 30) begin
            lv = 20; lg = 1163;  hv = 30;  hg = 2320;
        end else if (x <= 40) begin
            lv = 30; lg = 2320;  hv = 40;  hg = 4125;
        end else if (x <= 50) begin
            lv = 40; lg = 4125;  hv = 50;  hg = 6538;
        end else if (x <= 60) begin
            lv = 50; lg = 6538;  hv = 60;  hg = 10362;
        end else if (x <= 80) begin
            lv = 60; lg = 10362; hv = 80;  hg = 16423;
        end else begin
            lv = 80; lg = 16423; hv = 100; hg = 26214;
        end
        return 15'(lg + (hg - lg) * (x - lv) / (hv - lv));
    endfunction

    function automatic logic [6:0] speech_vol(input logic [6:0] v);
        if (v == 7'd0) return 7'd0;
        if (v < 7'd40) return 7'd20;
        return v - 7'd20;
    endfunction

    function automatic void gain_set(input logic [14:0] g);
        gain_now = g;
        gain_tgt = g;
        gain_beg = g;
        ramp_pos = '0;
        ramp_len = '0;
    endfunction

    function automatic void gain_retarget(input logic [14:0] g);
        logic [15:0] rem;
        rem = (ramp_len > ramp_pos) ? ramp_len - ramp_pos : 16'd0;
        gain_beg = gain_now;
        gain_tgt = g;
        ramp_pos = '0;
        ramp_len = rem;
        if (rem == 16'd0) gain_set(g);
    endfunction

    function automatic logic [14:0] ramp_step();
        longint g;
        if (ramp_pos < ramp_len) begin
            ramp_pos = ramp_pos + 16'd1;
            g = longint'(gain_beg) + (longint'(gain_tgt) - longint'(gain_beg))
                * longint'(ramp_pos) / longint'(ramp_len);
            gain_now = g[14:0];
            if (ramp_pos == ramp_len) gain_now = gain_tgt;
        end
        return gain_now;
    endfunction

    function automatic void volume_change(input logic [6:0] vin);
        logic [6:0]  v;
        logic [14:0] ug;
        v = (vin > VOL_MAX) ? VOL_MAX : vin;
        user_vol = v;
        ug = curve_gain(v);
        if (v == 7'd0 || cur_src == SRC_SYSTEM) begin
            gain_set(ug);
        end else if (cur_src == SRC_SPEECH) begin
            gain_beg = gain_now;
            gain_tgt = curve_gain(speech_vol(v));
            ramp_pos = '0;
            ramp_len = 16'(SPEECH_RAMP);
        end else if (ramp_len > ramp_pos) begin
            gain_retarget(ug);
        end else begin
            gain_set(ug);
        end
    endfunction

    function automatic void source_change(input logic [1:0] src, input logic st);
        bit          changed;
        logic [14:0] ug, ag;
        if (src > SRC_MEDIA) return;
        changed = (cur_src != src);
        cur_src = src;
        ug = curve_gain(user_vol);
        if (user_vol == 7'd0) begin
            gain_set(15'd0);
        end else if (src == SRC_SPEECH) begin
            ag = curve_gain(speech_vol(user_vol));
            if (changed || (ramp_pos >= ramp_len && gain_tgt != ag)) gain_set(ag);
        end else if (src == SRC_MEDIA && st) begin
            if (fade_len == 16'd0) begin
                gain_set(ug);
            end else begin
                gain_now = '0;
                gain_beg = '0;
                gain_tgt = ug;
                ramp_pos = '0;
                ramp_len = fade_len;
            end
        end else if (src == SRC_MEDIA && ramp_pos < ramp_len) begin
            if (gain_tgt != ug) gain_retarget(ug);
        end else begin
            gain_set(ug);
        end
    endfunction

    // returns 1 when the item gives a scaled sample
    function automatic bit gain_stage_step(input t_item it, output t_res r);
        longint      y;
        logic [14:0] g;
        r = '{default: '0};
        case (it.func)
            FUNC_VOLUME: begin
                volume_change(it.vol);
                return 1'b0;
            end
            FUNC_SOURCE: begin
                source_change(it.src, it.start);
                return 1'b0;
            end
            FUNC_SAMPLE: begin
                if (!out_en) return 1'b0;
                g = ramp_step();
                y = longint'(it.smp) * longint'(g) / longint'(GAIN_SCALE);
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                r.smp = y[15:0];
                r.gain = g;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_row item_row(input logic [1:0] f, input logic signed [15:0] s,
                                      input logic [6:0] v, input logic [1:0] src,
                                      input logic st, input bit typed,
                                      input logic signed [15:0] es, input logic [14:0] eg);
        t_row r;
        r.is_cfg = 1'b0;
        r.cfg_idx = REG_FADE_LEN;
        r.cfg_data = '0;
        r.it = '{f, s, v, src, st};
        r.typed = typed;
        r.res = '{es, eg};
        return r;
    endfunction

    function automatic t_row cfg_row(input logic idx, input logic [15:0] data);
        t_row r;
        r = item_row(FUNC_SAMPLE, 16'sd0, 7'd0, SRC_SYSTEM, 1'b0, 1'b0, 16'sd0, 15'd0);
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    r;
        r = $urandom_range(0, 99);
        it.smp = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
                0: it.smp = 16'sh7fff;
                1: it.smp = 16'sh8000;
                2: it.smp = 16'sd0;
                3: it.smp = -16'sd1;
                default: it.smp = 16'sd1;
            endcase
        end
        it.vol = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 7))
                0: it.vol = 7'd0;
                1: it.vol = 7'd5;
                2: it.vol = 7'd10;
                3: it.vol = 7'd20;
                4: it.vol = 7'd40;
                5: it.vol = 7'd80;
                6: it.vol = 7'd100;
                default: it.vol = 7'd127;
            endcase
        end
        it.src = ($urandom_range(0, 9) == 0) ? SRC_RESERVED : 2'($urandom_range(0, 2));
        it.start = 1'($urandom_range(0, 1));
        if (r < 70) it.func = FUNC_SAMPLE;
        else if (r < 82) it.func = FUNC_VOLUME;
        else if (r < 95) it.func = FUNC_SOURCE;
        else it.func = FUNC_RESERVED;
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_res typed_res);
        t_res pr;
        bit   got;
        int   n;
        @(negedge i_clk);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= it.func;
        i_sample_in <= it.smp;
        i_volume <= it.vol;
        i_source <= it.src;
        i_stream_start <= it.start;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        got = gain_stage_step(it, pr);
        if (got) expected_out.push_back(typed ? typed_res : pr);
        n_items++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == REG_FADE_LEN) fade_len = data;
        else out_en = data[0];
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender idle, all results in, then let the block finish any silent item
    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] fade, input bit en, input int useful,
                             input bit idle, input int hold_at);
        t_item it;
        t_res  nores;
        int    done;
        nores = '{default: '0};
        settle_block();
        write_reg(REG_FADE_LEN, fade);
        write_reg(REG_OUT_EN, {15'd0, en});
        tx_idle = idle;
        rx_idle = idle;
        done = 0;
        while (done < useful) begin
            if (done == hold_at) hold_req = 1'b1;
            it = rand_item();
            send_item(it, 1'b0, nores);
            if (!(it.func == FUNC_RESERVED || (it.func == FUNC_SOURCE && it.src == SRC_RESERVED)
                  || (it.func == FUNC_SAMPLE && !out_en))) done++;
        end
    endtask

    // receiver stalls
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 11);
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_out.size() == 0) begin
                report_fail($sformatf("result with nothing expected: sample %0d gain %0d",
                                      o_sample_out, o_gain_used));
            end else begin
                e = expected_out.pop_front();
                if (o_sample_out !== e.smp)
                    report_fail($sformatf("sample_out got %0d expected %0d",
                                          o_sample_out, e.smp));
                if (o_gain_used !== e.gain)
                    report_fail($sformatf("gain_used got %0d expected %0d",
                                          o_gain_used, e.gain));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_row row;
        fade_len = FADE_RESET;
        out_en = 1'b0;
        user_vol = VOL_RESET;
        cur_src = SRC_SYSTEM;
        gain_set(15'd0);

        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh7fff, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_OUT_EN, 16'd1));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh7fff, 7'd0, SRC_SYSTEM, 1'b0, 1, 0, 0));
        dir_rows.push_back(item_row(FUNC_VOLUME, 16'sd0, 7'd100, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh7fff, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, 16'sd26213, 15'd26214));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh8000, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, -16'sd26214, 15'd26214));
        dir_rows.push_back(item_row(FUNC_VOLUME, 16'sd0, 7'd127, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sd1, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, 16'sd0, 15'd26214));
        // reserved codes leave everything as it was
        dir_rows.push_back(item_row(FUNC_RESERVED, 16'sh8000, 7'd0, SRC_SYSTEM, 1'b1, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, -16'sd1, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, 16'sd0, 15'd26214));
        dir_rows.push_back(item_row(FUNC_SOURCE, 16'sd0, 7'd0, SRC_RESERVED, 1'b1, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh8000, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, -16'sd26214, 15'd26214));
        dir_rows.push_back(item_row(FUNC_VOLUME, 16'sd0, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh8000, 7'd0, SRC_SYSTEM, 1'b0, 1, 0, 0));
        dir_rows.push_back(item_row(FUNC_VOLUME, 16'sd0, 7'd50, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SOURCE, 16'sd0, 7'd0, SRC_SPEECH, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh7fff, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, 16'sd2319, 15'd2320));
        dir_rows.push_back(item_row(FUNC_VOLUME, 16'sd0, 7'd60, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, -16'sd12345, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SOURCE, 16'sd0, 7'd0, SRC_MEDIA, 1'b1, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sd20000, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_VOLUME, 16'sd0, 7'd80, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, -16'sd20000, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_FADE_LEN, 16'd0));
        dir_rows.push_back(item_row(FUNC_SOURCE, 16'sd0, 7'd0, SRC_MEDIA, 1'b1, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh7fff, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, 16'sd16422, 15'd16423));
        dir_rows.push_back(cfg_row(REG_FADE_LEN, 16'hffff));
        dir_rows.push_back(item_row(FUNC_SOURCE, 16'sd0, 7'd0, SRC_MEDIA, 1'b1, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh7fff, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SOURCE, 16'sd0, 7'd0, SRC_SYSTEM, 1'b0, 0, 0, 0));
        dir_rows.push_back(item_row(FUNC_SAMPLE, 16'sh8000, 7'd0, SRC_SYSTEM, 1'b0,
                                    1, -16'sd16423, 15'd16423));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                settle_block();
                write_reg(row.cfg_idx, row.cfg_data);
            end else begin
                send_item(row.it, row.typed, row.res);
            end
        end

        run_phase(16'd16, 1'b1, 150, 1'b1, -1);
        run_phase(FADE_RESET, 1'b1, 150, 1'b1, 30);
        run_phase(16'd1, 1'b1, 120, 1'b1, -1);
        run_phase(16'd0, 1'b1, 120, 1'b1, -1);
        run_phase(16'hffff, 1'b1, 100, 1'b1, -1);
        run_phase(16'd300, 1'b0, 40, 1'b1, -1);
        run_phase(16'($urandom_range(1, 200)), 1'b1, 100, 1'b1, -1);
        run_phase(16'd60, 1'b1, 100, 1'b0, -1);
        settle_block();

        if (expected_out.size() != 0)
            report_fail($sformatf("%0d results never arrived", expected_out.size()));
        $display("%0d items accepted, %0d results checked, %0d register writes",
                 n_items, n_results, n_cfg);
        $display("system, speech and media sources, fades of 0 to 65535, output off, reserved codes");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
